>>> rtl/double_ended_queue_unit_macros.svh
// Assertion macros for the double-ended queue unit checker.
// No dependencies; included by the checker file only.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define DEQU_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deque unit check failed");

// next-cycle implication
`define DEQU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deque unit check failed");

`endif

>>> rtl/dequ_pkg.sv
// Shared constants, command struct and index helpers for the deque unit.
// No dependencies.
`default_nettype none

package dequ_pkg;

	localparam int DEPTH     = 1024;
	localparam int WORD_BITS = 32;
	localparam int IDX_BITS  = $clog2(DEPTH);
	localparam int CNT_BITS  = $clog2(DEPTH + 1);

	localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
	localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
	localparam logic [2:0] OP_POP_BACK   = 3'd2;
	localparam logic [2:0] OP_POP_FRONT  = 3'd3;
	localparam logic [2:0] OP_CLEAR      = 3'd4;
	localparam logic [2:0] OP_QUERY      = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic accept;
		logic exec;
		logic capture;
		logic finish;
	} dequ_cmd_t;

	function automatic logic [IDX_BITS-1:0] idx_next(input logic [IDX_BITS-1:0] i);
		idx_next = (i == IDX_BITS'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_BITS-1:0] idx_prev(input logic [IDX_BITS-1:0] i);
		idx_prev = (i == '0) ? IDX_BITS'(DEPTH - 1) : i - 1'b1;
	endfunction

endpackage

`default_nettype wire

>>> rtl/dequ_ctrl.sv
// Sequencer of the deque unit: accept, execute, read, finish.
// Depends on dequ_pkg.
`default_nettype none

module dequ_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	output logic                   done,
	output dequ_pkg::dequ_cmd_t    cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_FIN
	} state_t;

	state_t state_q;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd.accept  = start && !busy;
		cmd.exec    = (state_q == S_EXEC);
		cmd.capture = (state_q == S_READ);
		cmd.finish  = (state_q == S_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_EXEC;
				end
				S_EXEC: state_q <= S_READ;
				S_READ: state_q <= S_FIN;
				S_FIN: begin
					state_q <= S_IDLE;
					done    <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/dequ_datapath.sv
// Datapath of the deque unit: ring store, indices, count and result registers.
// Depends on dequ_pkg.
`default_nettype none

module dequ_datapath (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dequ_pkg::dequ_cmd_t   cmd,
	input  wire logic [2:0]            op,
	input  wire logic signed [31:0]    push_value,
	output logic signed [31:0]         popped_value,
	output logic [1:0]                 status,
	output logic signed [31:0]         front_value,
	output logic signed [31:0]         back_value,
	output logic [10:0]                element_count,
	output logic                       is_empty
);

	localparam int IB = dequ_pkg::IDX_BITS;
	localparam int CB = dequ_pkg::CNT_BITS;
	localparam int WB = dequ_pkg::WORD_BITS;

	logic [WB-1:0] mem_q [dequ_pkg::DEPTH];
	logic [WB-1:0] rd_a_q;
	logic [WB-1:0] rd_b_q;

	logic [2:0]    op_q;
	logic [WB-1:0] val_q;
	logic [IB-1:0] front_q;
	logic [IB-1:0] back_q;
	logic [CB-1:0] count_q;
	logic          pop_ok_q;
	logic [1:0]    status_q;
	logic [WB-1:0] popped_q;

	logic          full;
	logic          empty;
	logic          we;
	logic [IB-1:0] wa;
	logic [IB-1:0] ra_a;
	logic [IB-1:0] ra_b;

	assign full  = (count_q == CB'(dequ_pkg::DEPTH));
	assign empty = (count_q == '0);
	assign ra_b  = dequ_pkg::idx_prev(back_q);

	always_comb begin
		we   = 1'b0;
		wa   = back_q;
		ra_a = front_q;
		if (cmd.exec) begin
			case (op_q)
				dequ_pkg::OP_PUSH_BACK: begin
					we = !full;
					wa = back_q;
				end
				dequ_pkg::OP_PUSH_FRONT: begin
					we = !full;
					wa = dequ_pkg::idx_prev(front_q);
				end
				dequ_pkg::OP_POP_BACK:  ra_a = dequ_pkg::idx_prev(back_q);
				dequ_pkg::OP_POP_FRONT: ra_a = front_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem_q[wa] <= val_q;
		rd_a_q <= mem_q[ra_a];
		rd_b_q <= mem_q[ra_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			case (op_q)
				dequ_pkg::OP_PUSH_BACK: begin
					if (!full) begin
						back_q  <= dequ_pkg::idx_next(back_q);
						count_q <= count_q + 1'b1;
					end
				end
				dequ_pkg::OP_PUSH_FRONT: begin
					if (!full) begin
						front_q <= dequ_pkg::idx_prev(front_q);
						count_q <= count_q + 1'b1;
					end
				end
				dequ_pkg::OP_POP_BACK: begin
					if (!empty) begin
						back_q  <= dequ_pkg::idx_prev(back_q);
						count_q <= count_q - 1'b1;
					end
				end
				dequ_pkg::OP_POP_FRONT: begin
					if (!empty) begin
						front_q <= dequ_pkg::idx_next(front_q);
						count_q <= count_q - 1'b1;
					end
				end
				dequ_pkg::OP_CLEAR: begin
					front_q <= '0;
					back_q  <= '0;
					count_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// item payload and result registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= op;
			val_q <= WB'(push_value);
		end
		if (cmd.exec) begin
			pop_ok_q <= 1'b0;
			status_q <= dequ_pkg::ST_OK;
			case (op_q) inside
				dequ_pkg::OP_PUSH_BACK, dequ_pkg::OP_PUSH_FRONT: begin
					if (full) status_q <= dequ_pkg::ST_FULL;
				end
				dequ_pkg::OP_POP_BACK, dequ_pkg::OP_POP_FRONT: begin
					if (empty) status_q <= dequ_pkg::ST_EMPTY;
					else pop_ok_q <= 1'b1;
				end
				default: ;
			endcase
		end
		if (cmd.capture) begin
			popped_q <= pop_ok_q ? rd_a_q : '0;
		end
		if (cmd.finish) begin
			popped_value  <= popped_q;
			status        <= status_q;
			front_value   <= empty ? '0 : rd_a_q;
			back_value    <= empty ? '0 : rd_b_q;
			element_count <= 11'(count_q);
			is_empty      <= empty;
		end
	end

endmodule

`default_nettype wire

>>> rtl/double_ended_queue_unit.sv
// Top level of the double-ended queue unit: sequencer plus datapath.
// Depends on dequ_pkg, dequ_ctrl, dequ_datapath.
//
//  channel   | handshake     | payload
//  ----------+---------------+----------------------------------------------
//  command   | start / busy  | op, push_value
//  result    | done strobe   | popped_value, status, front_value, back_value,
//            |               | element_count, is_empty
//
// An item is taken when start is high and busy low; its result strobes on done
// after execute, store read and result load. busy stays high through those
// steps, so a new item is taken only once the last one is through; a new item may
// be taken in the cycle the result strobes.
// Reset empties the queue; the store itself is not cleared and needs no pass.
// done is high for one cycle only; the outputs hold; there is no back-pressure.
`default_nettype none

module double_ended_queue_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         op,
	input  wire logic signed [31:0] push_value,
	output logic                    done,
	output logic signed [31:0]      popped_value,
	output logic [1:0]              status,
	output logic signed [31:0]      front_value,
	output logic signed [31:0]      back_value,
	output logic [10:0]             element_count,
	output logic                    is_empty
);

	dequ_pkg::dequ_cmd_t cmd;

	dequ_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	dequ_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.op            (op),
		.push_value    (push_value),
		.popped_value  (popped_value),
		.status        (status),
		.front_value   (front_value),
		.back_value    (back_value),
		.element_count (element_count),
		.is_empty      (is_empty)
	);

endmodule

`default_nettype wire

>>> rtl/dequ_checker.sv
// Port-level checks for the double-ended queue unit, bound to the top level.
// Depends on double_ended_queue_unit_macros.svh.
`default_nettype none

`include "double_ended_queue_unit_macros.svh"

module dequ_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic               done,
	input wire logic signed [31:0] popped_value,
	input wire logic [1:0]         status,
	input wire logic signed [31:0] front_value,
	input wire logic signed [31:0] back_value,
	input wire logic [10:0]        element_count,
	input wire logic               is_empty
);

	`DEQU_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`DEQU_ASSERT_SAME(a_latency, clk, arst_n, start && !busy, ##4 done)
	`DEQU_ASSERT_SAME(a_empty_flag, clk, arst_n, done, is_empty == (element_count == 11'd0))
	`DEQU_ASSERT_SAME(a_empty_zero, clk, arst_n, done && is_empty,
		front_value == 32'sd0 && back_value == 32'sd0 && element_count <= 11'd1024)
	`DEQU_ASSERT_SAME(a_pop_zero, clk, arst_n, done && status != 2'd0,
		popped_value == 32'sd0 && status != 2'd3)

endmodule

bind double_ended_queue_unit dequ_checker u_chk (.*);

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking bench for double_ended_queue_unit: directed edge cases, fill to full, random traffic.
// Depends on dequ_pkg and the unit itself. A shadow ring buffer predicts every result.
`timescale 1ns / 100ps

module tb;

	localparam int          CLK_PERIOD   = 10;
	localparam int          RESET_CYCLES = 7;
	localparam int          RUN_LIMIT_NS = 5_000_000;
	localparam int          PRINT_CAP    = 100;
	localparam logic [2:0]  OP_UNUSED_LO = 3'd6;
	localparam logic [2:0]  OP_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic signed [31:0] popped_word;
		logic [1:0]         status_code;
		logic signed [31:0] front_word;
		logic signed [31:0] back_word;
		logic [10:0]        word_count;
		logic               empty_flag;
	} deque_outcome_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [2:0]         op = dequ_pkg::OP_QUERY;
	logic signed [31:0] push_value = '0;
	logic               busy;
	logic               done;
	logic signed [31:0] popped_value;
	logic [1:0]         status;
	logic signed [31:0] front_value;
	logic signed [31:0] back_value;
	logic [10:0]        element_count;
	logic               is_empty;

	logic signed [31:0] shadow_words [dequ_pkg::DEPTH];
	int                 shadow_front = 0;
	int                 shadow_back = 0;
	int                 shadow_count = 0;
	deque_outcome_t     deque_outcomes [$];
	int                 mismatch_count = 0;
	int                 sender_idle_pct = 0;

	double_ended_queue_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.push_value(push_value),
		.done(done),
		.popped_value(popped_value),
		.status(status),
		.front_value(front_value),
		.back_value(back_value),
		.element_count(element_count),
		.is_empty(is_empty)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic deque_outcome_t apply_deque_op(logic [2:0] code, logic signed [31:0] word);
		deque_outcome_t r;
		r = '0;
		r.status_code = dequ_pkg::ST_OK;
		case (code)
			dequ_pkg::OP_PUSH_BACK: begin
				if (shadow_count >= dequ_pkg::DEPTH) begin
					r.status_code = dequ_pkg::ST_FULL;
				end else begin
					shadow_words[shadow_back] = word;
					shadow_back = (shadow_back + 1) % dequ_pkg::DEPTH;
					shadow_count++;
				end
			end
			dequ_pkg::OP_PUSH_FRONT: begin
				if (shadow_count >= dequ_pkg::DEPTH) begin
					r.status_code = dequ_pkg::ST_FULL;
				end else begin
					shadow_front = (shadow_front + dequ_pkg::DEPTH - 1) % dequ_pkg::DEPTH;
					shadow_words[shadow_front] = word;
					shadow_count++;
				end
			end
			dequ_pkg::OP_POP_BACK: begin
				if (shadow_count == 0) begin
					r.status_code = dequ_pkg::ST_EMPTY;
				end else begin
					shadow_back = (shadow_back + dequ_pkg::DEPTH - 1) % dequ_pkg::DEPTH;
					r.popped_word = shadow_words[shadow_back];
					shadow_count--;
				end
			end
			dequ_pkg::OP_POP_FRONT: begin
				if (shadow_count == 0) begin
					r.status_code = dequ_pkg::ST_EMPTY;
				end else begin
					r.popped_word = shadow_words[shadow_front];
					shadow_front = (shadow_front + 1) % dequ_pkg::DEPTH;
					shadow_count--;
				end
			end
			dequ_pkg::OP_CLEAR: begin
				shadow_front = 0;
				shadow_back = 0;
				shadow_count = 0;
			end
			default: ;
		endcase
		if (shadow_count != 0) begin
			r.front_word = shadow_words[shadow_front];
			r.back_word  = shadow_words[(shadow_back + dequ_pkg::DEPTH - 1) % dequ_pkg::DEPTH];
		end
		r.word_count = shadow_count[10:0];
		r.empty_flag = (shadow_count == 0);
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatch_count < PRINT_CAP)
			$display("%0t ns mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic compare_field(string field, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", field, got, want));
	endtask

	// inputs move on the falling edge; the item is taken at the next rising edge with busy low
	task automatic issue_command(logic [2:0] code, logic signed [31:0] word);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start      <= 1'b1;
		op         <= code;
		push_value <= word;
		while (busy)
			@(negedge clk);
		@(posedge clk);
		deque_outcomes.insert(deque_outcomes.size(), apply_deque_op(code, word));
	endtask

	always @(posedge clk) begin : check_results
		deque_outcome_t want;
		if (arst_n && done) begin
			if (deque_outcomes.size() == 0) begin
				report_mismatch("result strobe with no item outstanding");
			end else begin
				want = deque_outcomes[0];
				deque_outcomes.delete(0);
				compare_field("popped_value", popped_value, want.popped_word);
				compare_field("status", 32'(status), 32'(want.status_code));
				compare_field("front_value", front_value, want.front_word);
				compare_field("back_value", back_value, want.back_word);
				compare_field("element_count", 32'(element_count), 32'(want.word_count));
				compare_field("is_empty", 32'(is_empty), 32'(want.empty_flag));
			end
		end
	end

	task automatic test_edge_cases();
		issue_command(dequ_pkg::OP_POP_FRONT, 32'sd5);
		issue_command(dequ_pkg::OP_POP_BACK, -32'sd5);
		issue_command(dequ_pkg::OP_QUERY, 32'sd0);
		issue_command(OP_UNUSED_LO, 32'sh7fffffff);
		issue_command(OP_UNUSED_HI, 32'sh80000000);
		issue_command(dequ_pkg::OP_PUSH_FRONT, 32'sh7fffffff);  // front wraps below slot zero
		issue_command(dequ_pkg::OP_PUSH_BACK, 32'sh80000000);
		issue_command(dequ_pkg::OP_PUSH_BACK, 32'sd0);
		issue_command(dequ_pkg::OP_PUSH_FRONT, -32'sd1);
		issue_command(OP_UNUSED_HI, 32'sh12345678);
		issue_command(dequ_pkg::OP_QUERY, -32'sd1);
		issue_command(dequ_pkg::OP_POP_BACK, 32'sd0);
		issue_command(dequ_pkg::OP_POP_FRONT, 32'sd0);
		issue_command(dequ_pkg::OP_POP_FRONT, 32'sd0);
		issue_command(dequ_pkg::OP_POP_BACK, 32'sd0);
		issue_command(dequ_pkg::OP_POP_BACK, 32'sd0);
		issue_command(dequ_pkg::OP_PUSH_BACK, 32'sh55555555);
		issue_command(dequ_pkg::OP_PUSH_BACK, 32'shaaaaaaaa);
		issue_command(dequ_pkg::OP_CLEAR, 32'sh0f0f0f0f);
		issue_command(dequ_pkg::OP_QUERY, 32'sd0);
		issue_command(dequ_pkg::OP_POP_FRONT, 32'sd0);
		issue_command(dequ_pkg::OP_PUSH_FRONT, 32'sd1);
		issue_command(dequ_pkg::OP_POP_BACK, 32'sd0);
	endtask

	task automatic test_full_store();
		issue_command(dequ_pkg::OP_CLEAR, $urandom);
		while (shadow_count < dequ_pkg::DEPTH)
			issue_command($urandom_range(1) ? dequ_pkg::OP_PUSH_FRONT : dequ_pkg::OP_PUSH_BACK,
				$urandom);
		issue_command(dequ_pkg::OP_PUSH_BACK, $urandom);
		issue_command(dequ_pkg::OP_PUSH_FRONT, $urandom);
		issue_command(dequ_pkg::OP_QUERY, $urandom);
		issue_command(dequ_pkg::OP_POP_FRONT, $urandom);
		issue_command(dequ_pkg::OP_PUSH_BACK, $urandom);
		issue_command(dequ_pkg::OP_PUSH_FRONT, $urandom);
		issue_command(dequ_pkg::OP_POP_BACK, $urandom);
		issue_command(dequ_pkg::OP_POP_BACK, $urandom);
		issue_command(dequ_pkg::OP_CLEAR, $urandom);
	endtask

	task automatic test_random_traffic(int n_items, int push_pct);
		int         pick;
		logic [2:0] code;
		for (int i = 0; i < n_items; i++) begin
			pick = $urandom_range(99);
			if (pick < push_pct)
				code = $urandom_range(1) ? dequ_pkg::OP_PUSH_FRONT : dequ_pkg::OP_PUSH_BACK;
			else if (pick < 94)
				code = $urandom_range(1) ? dequ_pkg::OP_POP_FRONT : dequ_pkg::OP_POP_BACK;
			else if (pick < 96)
				code = dequ_pkg::OP_CLEAR;
			else
				case ($urandom_range(2))
					0: code = dequ_pkg::OP_QUERY;
					1: code = OP_UNUSED_LO;
					default: code = OP_UNUSED_HI;
				endcase
			issue_command(code, $urandom);
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		sender_idle_pct = 0;
		test_edge_cases();
		sender_idle_pct = 31;
		test_full_store();
		for (int k = 0; k < 4; k++) begin
			sender_idle_pct = (k == 1) ? 78 : (k == 3) ? 31 : 0;
			test_random_traffic(12, 62);
			test_random_traffic(12, 32);
		end

		@(negedge clk);
		start <= 1'b0;
		for (int n = 0; n < 200 && deque_outcomes.size() != 0; n++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (deque_outcomes.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", deque_outcomes.size()));

		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("end of test: mismatches");
		$finish;
	end

endmodule
